// ===== rtl/ac3fhp_pkg.sv =====
// Shared types, constants and lookup tables for the AC-3 frame header parser.
`default_nettype none
package ac3fhp_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int LEN_W           = 17;

    localparam logic [7:0]  SYNC_FIRST        = 8'h0B;
    localparam logic [7:0]  SYNC_SECOND       = 8'h77;
    localparam logic [15:0] POS_LIMIT         = 16'hFFFF;
    localparam logic [15:0] HDR_DIST_FIRST    = 16'd4;
    localparam logic [15:0] HDR_DIST_LAST     = 16'd6;
    localparam logic [1:0]  HDR_COUNT_FULL    = 2'd3;
    localparam logic [5:0]  FRMSIZE_LIMIT     = 6'd38;
    localparam logic [4:0]  BSID_LIMIT        = 5'd18;
    localparam logic [4:0]  BSID_REDUCE_BASE  = 5'd8;
    localparam logic [1:0]  FSCOD_48K         = 2'd0;
    localparam logic [1:0]  FSCOD_44K1        = 2'd1;
    localparam logic [1:0]  FSCOD_32K         = 2'd2;
    localparam logic [1:0]  FSCOD_RESERVED    = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        header_valid;
        logic [15:0] sample_rate_hz;
        logic [11:0] frame_size_bytes;
        logic [2:0]  channel_mode;
        logic        lfe_present;
        logic [2:0]  channel_count;
        logic        exact_frame;
    } t_out_item;

    // One finished buffer, handed from the scanner to the decoder.
    typedef struct packed {
        logic             hdr_ok;
        logic [2:0][7:0]  hdr;
        logic             sync_at_zero;
        logic [LEN_W-1:0] len;
        logic             well_framed;
    } t_frame_rec;

    function automatic logic [9:0] kbps_lut(input logic [4:0] idx);
        case (idx)
            5'd0:    kbps_lut = 10'd32;
            5'd1:    kbps_lut = 10'd40;
            5'd2:    kbps_lut = 10'd48;
            5'd3:    kbps_lut = 10'd56;
            5'd4:    kbps_lut = 10'd64;
            5'd5:    kbps_lut = 10'd80;
            5'd6:    kbps_lut = 10'd96;
            5'd7:    kbps_lut = 10'd112;
            5'd8:    kbps_lut = 10'd128;
            5'd9:    kbps_lut = 10'd160;
            5'd10:   kbps_lut = 10'd192;
            5'd11:   kbps_lut = 10'd224;
            5'd12:   kbps_lut = 10'd256;
            5'd13:   kbps_lut = 10'd320;
            5'd14:   kbps_lut = 10'd384;
            5'd15:   kbps_lut = 10'd448;
            5'd16:   kbps_lut = 10'd512;
            5'd17:   kbps_lut = 10'd576;
            5'd18:   kbps_lut = 10'd640;
            default: kbps_lut = 10'd0;
        endcase
    endfunction

    // floor(320 * kbps / 147), the 44.1 kHz word count per bitrate index
    function automatic logic [10:0] words_44k1_lut(input logic [4:0] idx);
        case (idx)
            5'd0:    words_44k1_lut = 11'd69;
            5'd1:    words_44k1_lut = 11'd87;
            5'd2:    words_44k1_lut = 11'd104;
            5'd3:    words_44k1_lut = 11'd121;
            5'd4:    words_44k1_lut = 11'd139;
            5'd5:    words_44k1_lut = 11'd174;
            5'd6:    words_44k1_lut = 11'd208;
            5'd7:    words_44k1_lut = 11'd243;
            5'd8:    words_44k1_lut = 11'd278;
            5'd9:    words_44k1_lut = 11'd348;
            5'd10:   words_44k1_lut = 11'd417;
            5'd11:   words_44k1_lut = 11'd487;
            5'd12:   words_44k1_lut = 11'd557;
            5'd13:   words_44k1_lut = 11'd696;
            5'd14:   words_44k1_lut = 11'd835;
            5'd15:   words_44k1_lut = 11'd975;
            5'd16:   words_44k1_lut = 11'd1114;
            5'd17:   words_44k1_lut = 11'd1253;
            5'd18:   words_44k1_lut = 11'd1393;
            default: words_44k1_lut = 11'd0;
        endcase
    endfunction

    function automatic logic [2:0] fullband_lut(input logic [2:0] acmod);
        case (acmod)
            3'd0:    fullband_lut = 3'd2;
            3'd1:    fullband_lut = 3'd1;
            3'd2:    fullband_lut = 3'd2;
            3'd3:    fullband_lut = 3'd3;
            3'd4:    fullband_lut = 3'd3;
            3'd5:    fullband_lut = 3'd4;
            3'd6:    fullband_lut = 3'd4;
            default: fullband_lut = 3'd5;
        endcase
    endfunction

    function automatic logic [15:0] base_rate_lut(input logic [1:0] fscod);
        case (fscod)
            FSCOD_48K:  base_rate_lut = 16'd48000;
            FSCOD_44K1: base_rate_lut = 16'd44100;
            FSCOD_32K:  base_rate_lut = 16'd32000;
            default:    base_rate_lut = 16'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ac3fhp_front.sv =====
// Byte scanner: finds the sync pair, captures header bytes, emits one record per buffer.
`default_nettype none
module ac3fhp_front
    import ac3fhp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire t_in_item   i_item,
    input  wire logic       i_well_framed,
    output logic            o_push,
    output t_frame_rec      o_rec
);

    logic [7:0]      r_prev,     n_prev;
    logic            r_sync_seen, n_sync_seen;
    logic [15:0]     r_pos,      n_pos;
    logic [15:0]     r_sync_pos, n_sync_pos;
    logic [2:0][7:0] r_hdr,      n_hdr;
    logic [1:0]      r_hcnt,     n_hcnt;

    logic [15:0] hdr_dist;
    logic [15:0] dist_off;
    logic        in_range;

    assign hdr_dist = r_pos - r_sync_pos;
    assign dist_off = hdr_dist - HDR_DIST_FIRST;
    assign in_range = (r_pos != POS_LIMIT);

    always_comb begin
        n_prev      = i_item.data_byte;
        n_sync_seen = r_sync_seen;
        n_pos       = r_pos;
        n_sync_pos  = r_sync_pos;
        n_hdr       = r_hdr;
        n_hcnt      = r_hcnt;
        if (in_range) begin
            if (!r_sync_seen) begin
                if ((r_pos != 16'd0) && (r_prev == SYNC_FIRST)
                        && (i_item.data_byte == SYNC_SECOND)) begin
                    n_sync_seen = 1'b1;
                    n_sync_pos  = r_pos - 16'd1;
                end
            end else if (r_hcnt != HDR_COUNT_FULL) begin
                if ((hdr_dist >= HDR_DIST_FIRST) && (hdr_dist <= HDR_DIST_LAST)) begin
                    n_hdr[dist_off[1:0]] = i_item.data_byte;
                    n_hcnt               = r_hcnt + 2'd1;
                end
            end
            n_pos = r_pos + 16'd1;
        end
    end

    // Record built from the state after this byte.
    always_comb begin
        o_push             = i_take && i_item.last_byte;
        o_rec.hdr_ok       = n_sync_seen && (n_hcnt == HDR_COUNT_FULL);
        o_rec.hdr          = n_hdr;
        o_rec.sync_at_zero = (n_sync_pos == 16'd0);
        o_rec.len          = in_range ? ({1'b0, r_pos} + 17'd1) : 17'h10000;
        o_rec.well_framed  = i_well_framed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_sync_seen <= 1'b0;
            r_pos       <= '0;
            r_sync_pos  <= '0;
            r_hcnt      <= '0;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                // drop stream state, start the next buffer clean
                r_prev      <= '0;
                r_sync_seen <= 1'b0;
                r_pos       <= '0;
                r_sync_pos  <= '0;
                r_hcnt      <= '0;
            end else begin
                r_prev      <= n_prev;
                r_sync_seen <= n_sync_seen;
                r_pos       <= n_pos;
                r_sync_pos  <= n_sync_pos;
                r_hcnt      <= n_hcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_hdr <= n_hdr;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ac3fhp_queue.sv =====
// Short record queue between the scanner and the decoder.
`default_nettype none
module ac3fhp_queue
    import ac3fhp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_frame_rec i_rec,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output t_frame_rec      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame_rec       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == CNT_FULL);
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ac3fhp_back.sv =====
// Header decoder: turns one buffer record into the result and holds it for the output transfer.
`default_nettype none
module ac3fhp_back
    import ac3fhp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rec_valid,
    input  wire t_frame_rec i_rec,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_data
);

    logic [1:0]  fscod;
    logic [5:0]  frmsizecod;
    logic [4:0]  bsid;
    logic [2:0]  acmod;
    logic        fields_ok;
    logic        lfe;
    logic [9:0]  kbps;
    logic [10:0] words_44k1;
    logic [11:0] size;
    logic [4:0]  reduce;
    t_out_item   res;
    logic        r_valid;
    t_out_item   r_data;

    always_comb begin
        fscod      = i_rec.hdr[0][7:6];
        frmsizecod = i_rec.hdr[0][5:0];
        bsid       = i_rec.hdr[1][7:3];
        acmod      = i_rec.hdr[2][7:5];
        fields_ok  = i_rec.hdr_ok && (frmsizecod < FRMSIZE_LIMIT)
                     && (bsid < BSID_LIMIT) && (fscod != FSCOD_RESERVED);

        // LFE bit position moves down as more optional fields precede it
        unique case (acmod)
            3'd0, 3'd1:             lfe = i_rec.hdr[2][4];
            3'd2, 3'd3, 3'd4, 3'd6: lfe = i_rec.hdr[2][2];
            default:                lfe = i_rec.hdr[2][0];
        endcase

        kbps       = kbps_lut(frmsizecod[5:1]);
        words_44k1 = words_44k1_lut(frmsizecod[5:1]) + {10'd0, frmsizecod[0]};
        unique case (fscod)
            FSCOD_48K:  size = {kbps, 2'b00};
            FSCOD_44K1: size = {words_44k1, 1'b0};
            default:    size = 12'(kbps) * 12'd6;
        endcase

        reduce = (bsid > BSID_REDUCE_BASE) ? (bsid - BSID_REDUCE_BASE) : 5'd0;

        res = '0;
        if (fields_ok) begin
            res.header_valid     = 1'b1;
            res.sample_rate_hz   = base_rate_lut(fscod) >> reduce;
            res.frame_size_bytes = size;
            res.channel_mode     = acmod;
            res.lfe_present      = lfe;
            res.channel_count    = fullband_lut(acmod) + {2'd0, lfe};
            res.exact_frame      = i_rec.well_framed && i_rec.sync_at_zero
                                   && (i_rec.len == {5'd0, size});
        end
    end

    assign o_pop   = i_rec_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= res;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ac3_frame_header_parser_core.sv =====
// Top level of the AC-3 frame header parser: scanner, record queue, decoder.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+--------------------------
//  byte in   | in        | i_valid / o_ready   | i_data  (t_in_item)
//  result    | out       | o_valid / i_ready   | o_data  (t_out_item)
//  config    | in        | i_cfg_we            | i_cfg_wdata (well_framed)
//
// One byte is taken per cycle while o_ready is high. When the queue is empty, a
// result passes from its last byte through the record queue and then the
// decoder's output register. o_ready drops only while the record
// queue is full, i.e. when results back up on the output side.
// Synchronous active-low reset clears stream state and the config register.
`default_nettype none
module ac3_frame_header_parser_core
    import ac3fhp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata
);

    logic       r_well_framed;
    logic       take;
    logic       push;
    t_frame_rec push_rec;
    logic       q_full;
    logic       q_nonempty;
    t_frame_rec q_head;
    logic       pop;

    assign o_ready = !q_full;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_well_framed <= 1'b0;
        end else if (i_cfg_we) begin
            r_well_framed <= i_cfg_wdata;
        end
    end

    ac3fhp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_item        (i_data),
        .i_well_framed (r_well_framed),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    ac3fhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rec      (push_rec),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    ac3fhp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (q_nonempty),
        .i_rec       (q_head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("record pushed into full queue");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.header_valid) |-> (o_data.sample_rate_hz == 16'd0
            && o_data.frame_size_bytes == 12'd0 && o_data.channel_mode == 3'd0
            && o_data.lfe_present == 1'b0 && o_data.channel_count == 3'd0
            && o_data.exact_frame == 1'b0))
        else $error("invalid result carries nonzero fields");

    a_valid_has_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.header_valid) |-> (o_data.sample_rate_hz != 16'd0
            && o_data.frame_size_bytes != 12'd0 && o_data.channel_count != 3'd0))
        else $error("valid header with empty rate, size or channel count");

    a_pop_needs_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_valid)
        else $error("decoder popped a record but shows no result");
`endif

endmodule
`default_nettype wire
